FILE: rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg: shared types and constants for the pileup base counter
// Character codes, counter slots, parser modes and majority codes.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int COUNT_BITS_DEF = 16;   // default counter width
    localparam int OUT_W          = 16;   // width of a count field on the port
    localparam int LEN_W          = 16;   // indel length / skip counter width
    localparam int THR_W          = 17;   // majority threshold width
    localparam int FRAC_BITS      = 16;   // threshold is a Q16 fraction
    localparam int NUM_SLOTS      = 5;
    localparam int NUM_CALL       = 4;    // A, T, G, C take part in the call

    localparam logic [THR_W-1:0] THR_RESET = 17'd52429;
    localparam logic [LEN_W-1:0] LEN_MAX   = 16'hFFFF;

    // counter slots
    localparam logic [2:0] SLOT_A = 3'd0;
    localparam logic [2:0] SLOT_T = 3'd1;
    localparam logic [2:0] SLOT_G = 3'd2;
    localparam logic [2:0] SLOT_C = 3'd3;
    localparam logic [2:0] SLOT_N = 3'd4;

    // characters of the base string
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_DIGITS,
        MODE_SKIP
    } mode_t;

    typedef enum logic [2:0] {
        MAJ_NONE,
        MAJ_A,
        MAJ_T,
        MAJ_G,
        MAJ_C
    } major_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } slot_t;

    // counter slot of an upper-case base letter
    function automatic slot_t slot_of(input logic [7:0] ch);
        slot_t s;
        s.hit = 1'b1;
        s.idx = SLOT_A;
        unique case (ch)
            CH_A:    s.idx = SLOT_A;
            CH_T:    s.idx = SLOT_T;
            CH_G:    s.idx = SLOT_G;
            CH_C:    s.idx = SLOT_C;
            CH_N:    s.idx = SLOT_N;
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/pbc_parser.sv
// ----------------------------------------------------------------------------
// pbc_parser: base string parser and counters
// Walks the base string one word per cycle while words are accepted, keeps the
// five counters and hands a snapshot of the updated state out on the last character.
// ----------------------------------------------------------------------------
module pbc_parser #(
    parameter int COUNT_BITS = pbc_pkg::COUNT_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   acc,
    input  logic [7:0]                             pileup_char,
    input  logic [7:0]                             ref_base,
    input  logic                                   end_mark,
    output logic                                   snap_valid,
    output logic [pbc_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0] snap_counts,
    output logic                                   snap_err
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    pbc_pkg::mode_t                                  mode_reg, mode_next;
    logic [pbc_pkg::LEN_W-1:0]                       len_reg, len_next;
    logic [pbc_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                                            err_reg, err_next;

    logic                       bump_en;
    logic [2:0]                 bump_idx;
    logic [7:0]                 up;
    pbc_pkg::slot_t             ch_slot;
    pbc_pkg::slot_t             ref_slot;
    logic                       is_digit;
    logic [pbc_pkg::LEN_W+3:0]  len_acc;
    logic [pbc_pkg::LEN_W-1:0]  len_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pbc_pkg::MODE_NORMAL;
            len_reg  <= '0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (acc) begin
            if (end_mark) begin
                mode_reg <= pbc_pkg::MODE_NORMAL;
                len_reg  <= '0;
                cnt_reg  <= '0;
                err_reg  <= 1'b0;
            end else begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                cnt_reg  <= cnt_next;
                err_reg  <= err_next;
            end
        end
    end

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        err_next  = err_reg;
        bump_en   = 1'b0;
        bump_idx  = pbc_pkg::SLOT_A;

        is_digit = (pileup_char >= pbc_pkg::CH_ZERO) && (pileup_char <= pbc_pkg::CH_NINE);
        len_acc  = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1)
                 + {{pbc_pkg::LEN_W{1'b0}}, pileup_char[3:0]};
        len_dec  = len_reg - pbc_pkg::LEN_W'(1);
        up       = ((pileup_char >= pbc_pkg::CH_LOW_A) && (pileup_char <= pbc_pkg::CH_LOW_Z))
                 ? pileup_char - pbc_pkg::CASE_OFS : pileup_char;
        ch_slot  = pbc_pkg::slot_of(up);
        ref_slot = pbc_pkg::slot_of(ref_base);

        if (!err_reg) begin
            unique case (mode_reg)
                pbc_pkg::MODE_DIGITS: begin
                    if (is_digit) begin
                        len_next = (len_acc > {4'b0, pbc_pkg::LEN_MAX})
                                 ? pbc_pkg::LEN_MAX : len_acc[pbc_pkg::LEN_W-1:0];
                    end else if (len_reg != '0) begin
                        // this character is the first one skipped
                        len_next  = len_dec;
                        mode_next = (len_dec != '0) ? pbc_pkg::MODE_SKIP
                                                    : pbc_pkg::MODE_NORMAL;
                    end
                end
                pbc_pkg::MODE_SKIP: begin
                    if (len_reg != '0) begin
                        len_next = len_dec;
                    end
                    if ((len_reg == '0) || (len_dec == '0)) begin
                        mode_next = pbc_pkg::MODE_NORMAL;
                    end
                end
                default: ;
            endcase

            // a normal character, or the first non-digit after an empty indel
            if ((mode_reg == pbc_pkg::MODE_NORMAL)
                || ((mode_reg == pbc_pkg::MODE_DIGITS) && !is_digit && (len_reg == '0))) begin
                mode_next = pbc_pkg::MODE_NORMAL;
                if (ch_slot.hit) begin
                    bump_en  = 1'b1;
                    bump_idx = ch_slot.idx;
                end else if ((up == pbc_pkg::CH_DOT) || (up == pbc_pkg::CH_COMMA)) begin
                    bump_en  = ref_slot.hit;
                    bump_idx = ref_slot.idx;
                end else if ((up == pbc_pkg::CH_PLUS) || (up == pbc_pkg::CH_MINUS)) begin
                    mode_next = pbc_pkg::MODE_DIGITS;
                    len_next  = '0;
                end else if (up == pbc_pkg::CH_CARET) begin
                    mode_next = pbc_pkg::MODE_SKIP;
                    len_next  = pbc_pkg::LEN_W'(1);
                end else if ((up == pbc_pkg::CH_LT) || (up == pbc_pkg::CH_GT)
                             || (up == pbc_pkg::CH_STAR)) begin
                    bump_en  = 1'b1;
                    bump_idx = pbc_pkg::SLOT_N;
                end else if (up != pbc_pkg::CH_DOLLAR) begin
                    err_next = 1'b1;
                end
            end
        end

        for (int k = 0; k < pbc_pkg::NUM_SLOTS; k++) begin
            cnt_next[k] = cnt_reg[k];
            if (bump_en && (bump_idx == 3'(k)) && (cnt_reg[k] != CNT_MAX)) begin
                cnt_next[k] = cnt_reg[k] + COUNT_BITS'(1);
            end
        end
    end

    assign snap_valid  = acc && end_mark;
    assign snap_counts = cnt_next;
    assign snap_err    = err_next;

endmodule

FILE: rtl/pbc_majority.sv
// ----------------------------------------------------------------------------
// pbc_majority: majority call pipeline and result register
// Total, threshold product and compare each take a stage; the last stage
// is the result register on the m_ side. Bubbles collapse under stall.
// ----------------------------------------------------------------------------
module pbc_majority #(
    parameter int COUNT_BITS = pbc_pkg::COUNT_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic [pbc_pkg::THR_W-1:0]                     thr,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [pbc_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0] in_counts,
    input  logic                                          in_err,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [pbc_pkg::NUM_SLOTS-1:0][pbc_pkg::OUT_W-1:0] out_counts,
    output logic [2:0]                                    out_major,
    output logic                                          out_err
);

    localparam int TOT_W  = COUNT_BITS + 2;
    localparam int PROD_W = TOT_W + pbc_pkg::THR_W;

    typedef logic [pbc_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0] cnt_arr_t;

    // stage 1: snapshot
    logic     v1_reg;
    cnt_arr_t cnt1_reg;
    logic     err1_reg;
    // stage 2: total
    logic             v2_reg;
    cnt_arr_t         cnt2_reg;
    logic             err2_reg;
    logic [TOT_W-1:0] tot2_reg;
    logic [TOT_W-1:0] tot2_next;
    // stage 3: threshold times total
    logic              v3_reg;
    cnt_arr_t          cnt3_reg;
    logic              err3_reg;
    logic              nz3_reg;
    logic [PROD_W-1:0] prod3_reg;
    logic [PROD_W-1:0] prod3_next;
    // output stage
    logic   vo_reg;
    logic [pbc_pkg::NUM_SLOTS-1:0][pbc_pkg::OUT_W-1:0] cnto_reg, cnto_next;
    logic   erro_reg;
    pbc_pkg::major_t maj_reg, maj_next;

    logic                       rdy1, rdy2, rdy3, rdyo;
    logic [pbc_pkg::NUM_CALL-1:0] qual;
    logic [31:0]                wide;

    assign rdyo     = !vo_reg || out_ready;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            cnt1_reg <= in_counts;
            err1_reg <= in_err;
        end
        if (rdy2 && v1_reg) begin
            cnt2_reg <= cnt1_reg;
            err2_reg <= err1_reg;
            tot2_reg <= tot2_next;
        end
        if (rdy3 && v2_reg) begin
            cnt3_reg  <= cnt2_reg;
            err3_reg  <= err2_reg;
            nz3_reg   <= (tot2_reg != '0);
            prod3_reg <= prod3_next;
        end
        if (rdyo && v3_reg) begin
            cnto_reg <= cnto_next;
            erro_reg <= err3_reg;
            maj_reg  <= maj_next;
        end
    end

    always_comb begin
        tot2_next = TOT_W'(cnt1_reg[pbc_pkg::SLOT_A]) + TOT_W'(cnt1_reg[pbc_pkg::SLOT_T])
                  + TOT_W'(cnt1_reg[pbc_pkg::SLOT_G]) + TOT_W'(cnt1_reg[pbc_pkg::SLOT_C]);
        prod3_next = PROD_W'(thr) * PROD_W'(tot2_reg);
    end

    always_comb begin
        wide = '0;
        for (int k = 0; k < pbc_pkg::NUM_CALL; k++) begin
            qual[k] = PROD_W'({cnt3_reg[k], {pbc_pkg::FRAC_BITS{1'b0}}}) >= prod3_reg;
        end
        for (int k = 0; k < pbc_pkg::NUM_SLOTS; k++) begin
            wide         = 32'(cnt3_reg[k]);
            cnto_next[k] = wide[pbc_pkg::OUT_W-1:0];
        end
        // first qualifying base in A, T, G, C order
        if (!nz3_reg)     maj_next = pbc_pkg::MAJ_NONE;
        else if (qual[0]) maj_next = pbc_pkg::MAJ_A;
        else if (qual[1]) maj_next = pbc_pkg::MAJ_T;
        else if (qual[2]) maj_next = pbc_pkg::MAJ_G;
        else if (qual[3]) maj_next = pbc_pkg::MAJ_C;
        else              maj_next = pbc_pkg::MAJ_NONE;
    end

    assign out_valid  = vo_reg;
    assign out_counts = cnto_reg;
    assign out_major  = maj_reg;
    assign out_err    = erro_reg;

endmodule

FILE: rtl/pileup_base_counter_top.sv
// ----------------------------------------------------------------------------
// pileup_base_counter_top: pileup base string counter
// Counts the bases of one pileup base string and calls the majority base.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one character of the base string per word, with the
//   reference base and a last-character mark. A word is taken on any cycle
//   where s_valid and s_ready are high, so a string streams at one word per
//   cycle while s_ready is high; a new string may start right after the last word.
//   m_ channel: one result word per string, with the five counts, the
//   majority call (0 none, 1 A, 2 T, 3 G, 4 C) and the bad-character flag.
//   m_valid rises when the result register loads, after snapshot, total and product.
//   Up to four results may be in flight; s_ready only drops when all of
//   them are held by a stalled m_ side, and rises again as soon as m_ready
//   frees a slot (combinational path from m_ready to s_ready).
//   cfg_we writes the Q16 majority threshold; write it while idle.
//   Reset clears the parser, the counters and the result pipeline and loads
//   the threshold with its default of about 0.8.
// ----------------------------------------------------------------------------
module pileup_base_counter_top #(
    parameter int COUNT_BITS = pbc_pkg::COUNT_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic [pbc_pkg::THR_W-1:0] cfg_wdata,
    // input words
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_pileup_char,
    input  logic [7:0]                s_ref_base,
    input  logic                      s_end_mark,
    // result words
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [15:0]               m_count_a,
    output logic [15:0]               m_count_t,
    output logic [15:0]               m_count_g,
    output logic [15:0]               m_count_c,
    output logic [15:0]               m_count_n,
    output logic [2:0]                m_major_base,
    output logic                      m_bad_char
);

    logic [pbc_pkg::THR_W-1:0] thr_reg;

    logic                                          acc;
    logic                                          snap_valid;
    logic [pbc_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0] snap_counts;
    logic                                          snap_err;
    logic [pbc_pkg::NUM_SLOTS-1:0][pbc_pkg::OUT_W-1:0] res_counts;

    // hold the threshold; the user must write it only between strings, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= pbc_pkg::THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // advance the parser on every accepted word
    assign acc = s_valid && s_ready;

    pbc_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .acc         (acc),
        .pileup_char (s_pileup_char),
        .ref_base    (s_ref_base),
        .end_mark    (s_end_mark),
        .snap_valid  (snap_valid),
        .snap_counts (snap_counts),
        .snap_err    (snap_err)
    );

    // s_ready follows the snapshot slot: a last word always needs room there
    pbc_majority #(
        .COUNT_BITS (COUNT_BITS)
    ) u_majority (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .thr        (thr_reg),
        .in_valid   (snap_valid),
        .in_ready   (s_ready),
        .in_counts  (snap_counts),
        .in_err     (snap_err),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_counts (res_counts),
        .out_major  (m_major_base),
        .out_err    (m_bad_char)
    );

    assign m_count_a = res_counts[pbc_pkg::SLOT_A];
    assign m_count_t = res_counts[pbc_pkg::SLOT_T];
    assign m_count_g = res_counts[pbc_pkg::SLOT_G];
    assign m_count_c = res_counts[pbc_pkg::SLOT_C];
    assign m_count_n = res_counts[pbc_pkg::SLOT_N];

endmodule

FILE: dv/tb_pileup_base_counter_top.sv
// ----------------------------------------------------------------------------
// tb_pileup_base_counter_top: self-checking bench for the pileup base counter
// Streams pileup base strings through the s_ side, predicts each result word
// (five counts, majority call, bad-character flag) and checks the m_ side
// field by field, over several threshold settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_pileup_base_counter_top;
    import pbc_pkg::*;

    typedef logic [7:0] char_q_t [$];

    // one expected or observed result word
    typedef struct {
        logic [OUT_W-1:0] a, t, g, c, n;
        logic [2:0]       major;
        logic             bad;
    } tally_t;

    // Tracks the parser state of the block, turns every accepted character
    // into the result word it causes, and checks result words in order.
    class base_tally_board;
        mode_t            mode;
        logic [LEN_W-1:0] span;              // indel digits so far, or chars left to skip
        logic [OUT_W-1:0] cnt [NUM_SLOTS];   // A, T, G, C, N; the DUT keeps its default width
        bit               err;
        logic [THR_W-1:0] thr;
        tally_t           due [$];
        int               fails;

        function new();
            thr   = THR_RESET;
            fails = 0;
            restart();
        endfunction

        function void restart();
            mode = MODE_NORMAL;
            span = '0;
            foreach (cnt[k]) cnt[k] = '0;
            err  = 1'b0;
        endfunction

        function int letter_slot(logic [7:0] ch);
            case (ch)
                CH_A:    return SLOT_A;
                CH_T:    return SLOT_T;
                CH_G:    return SLOT_G;
                CH_C:    return SLOT_C;
                CH_N:    return SLOT_N;
                default: return -1;
            endcase
        endfunction

        function void bump(int k);
            if (k >= 0 && cnt[k] != '1) cnt[k]++;
        endfunction

        function void plain_char(logic [7:0] ch, logic [7:0] rb);
            logic [7:0] up;
            up = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_OFS : ch;
            if (letter_slot(up) >= 0) bump(letter_slot(up));
            else if (up == CH_DOT || up == CH_COMMA) bump(letter_slot(rb));
            else if (up == CH_PLUS || up == CH_MINUS) begin
                mode = MODE_DIGITS;
                span = '0;
            end else if (up == CH_CARET) begin
                mode = MODE_SKIP;
                span = 16'd1;
            end else if (up == CH_LT || up == CH_GT || up == CH_STAR) bump(SLOT_N);
            else if (up != CH_DOLLAR) err = 1'b1;
        endfunction

        // first of A, T, G, C whose share of the non-N total reaches thr
        function logic [2:0] majority();
            longint unsigned total, lhs, rhs;
            major_t          pick [NUM_CALL];
            pick  = '{MAJ_A, MAJ_T, MAJ_G, MAJ_C};
            total = 0;
            for (int k = 0; k < NUM_CALL; k++) total += cnt[k];
            if (total == 0) return MAJ_NONE;
            for (int k = 0; k < NUM_CALL; k++) begin
                lhs = cnt[k];
                lhs = lhs << FRAC_BITS;
                rhs = thr;
                rhs = rhs * total;
                if (lhs >= rhs) return pick[k];
            end
            return MAJ_NONE;
        endfunction

        function void take_char(logic [7:0] ch, logic [7:0] rb, logic lst);
            int unsigned v;
            tally_t      res;
            if (!err) begin
                case (mode)
                    MODE_DIGITS: begin
                        if (ch >= CH_ZERO && ch <= CH_NINE) begin
                            v    = span * 10 + (ch - CH_ZERO);
                            span = (v > LEN_MAX) ? LEN_MAX : v[15:0];
                        end else if (span == 0) begin
                            mode = MODE_NORMAL;
                            plain_char(ch, rb);
                        end else begin
                            // this character is the first one skipped
                            span--;
                            mode = (span != 0) ? MODE_SKIP : MODE_NORMAL;
                        end
                    end
                    MODE_SKIP: begin
                        if (span != 0) span--;
                        if (span == 0) mode = MODE_NORMAL;
                    end
                    default: begin
                        mode = MODE_NORMAL;
                        plain_char(ch, rb);
                    end
                endcase
            end
            if (lst) begin
                res.a     = cnt[SLOT_A];
                res.t     = cnt[SLOT_T];
                res.g     = cnt[SLOT_G];
                res.c     = cnt[SLOT_C];
                res.n     = cnt[SLOT_N];
                res.major = majority();
                res.bad   = err;
                due.insert(due.size(), res);
                restart();
            end
        endfunction

        function void match_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_call(tally_t got);
            tally_t want;
            if (due.size() == 0) begin
                $error("result word arrived with no string pending");
                fails++;
                return;
            end
            want = due.pop_front();
            match_field("count_a", want.a, got.a);
            match_field("count_t", want.t, got.t);
            match_field("count_g", want.g, got.g);
            match_field("count_c", want.c, got.c);
            match_field("count_n", want.n, got.n);
            match_field("major_base", want.major, got.major);
            match_field("bad_char", want.bad, got.bad);
        endfunction
    endclass

    // cycles with no word moving on either side before the run is declared hung;
    // covers the long m_ side hold-off and the pauses around threshold writes
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_LEN    = 300;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_pileup_char;
    logic [7:0]       s_ref_base;
    logic             s_end_mark;
    logic             m_valid;
    logic             m_ready;
    logic [15:0]      m_count_a;
    logic [15:0]      m_count_t;
    logic [15:0]      m_count_g;
    logic [15:0]      m_count_c;
    logic [15:0]      m_count_n;
    logic [2:0]       m_major_base;
    logic             m_bad_char;

    base_tally_board board = new();

    int tx_idle_pct  = 15;   // chance in 100 that the sender skips a cycle
    int rx_idle_pct  = 74;   // chance in 100 that the receiver stalls a cycle
    int hold_cycles  = 0;    // set to make the receiver hold off for a stretch
    int chars_sent   = 0;
    int quiet_cycles = 0;

    pileup_base_counter_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pileup_char (s_pileup_char),
        .s_ref_base    (s_ref_base),
        .s_end_mark    (s_end_mark),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count_a     (m_count_a),
        .m_count_t     (m_count_t),
        .m_count_g     (m_count_g),
        .m_count_c     (m_count_c),
        .m_count_n     (m_count_n),
        .m_major_base  (m_major_base),
        .m_bad_char    (m_bad_char)
    );

    always #6 aclk = ~aclk;

    // Sample both channels at the rising edge; inputs only move on the falling
    // edge, so every value seen here is settled. Count quiet cycles for the
    // watchdog.
    always @(posedge aclk) begin
        tally_t got;
        if (aresetn) begin
            if (s_valid && s_ready)
                board.take_char(s_pileup_char, s_ref_base, s_end_mark);
            if (m_valid && m_ready) begin
                got.a     = m_count_a;
                got.t     = m_count_t;
                got.g     = m_count_g;
                got.c     = m_count_c;
                got.n     = m_count_n;
                got.major = m_major_base;
                got.bad   = m_bad_char;
                board.check_call(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off completely while a hold-off is
    // requested; one m_ready update per falling edge.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one word and hold it until taken. Call and return on a falling edge.
    task automatic send_char(logic [7:0] ch, logic [7:0] rb, logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pileup_char <= ch;
        s_ref_base    <= rb;
        s_end_mark    <= lst;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        chars_sent++;
    endtask

    // Send a whole base string; the last character carries the last mark.
    task automatic send_string(char_q_t q, logic [7:0] rb, bit vary_ref);
        for (int i = 0; i < q.size(); i++)
            send_char(q[i], vary_ref ? 8'($urandom_range(255)) : rb, i == q.size() - 1);
    endtask

    function automatic char_q_t to_chars(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
        return q;
    endfunction

    // Mostly well-formed pileup: bases, ref matches, gap marks, read starts and
    // indels with matching lengths; a few broken indels and stray bytes.
    function automatic char_q_t random_read();
        char_q_t q;
        string   bases = "ATGCNatgcn";
        string   digits;
        int      n, kind, len;
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
        repeat (n) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                q.insert(q.size(), bases[$urandom_range(9)]);
            end else if (kind < 58) begin
                q.insert(q.size(), $urandom_range(1) ? CH_DOT : CH_COMMA);
            end else if (kind < 64) begin
                case ($urandom_range(2))
                    0:       q.insert(q.size(), CH_LT);
                    1:       q.insert(q.size(), CH_GT);
                    default: q.insert(q.size(), CH_STAR);
                endcase
            end else if (kind < 68) begin
                q.insert(q.size(), CH_DOLLAR);
            end else if (kind < 75) begin
                // read start plus its mapping-quality byte
                q.insert(q.size(), CH_CARET);
                q.insert(q.size(), $urandom_range(1) ? 8'($urandom_range(33, 126))
                                                     : 8'($urandom_range(255)));
            end else if (kind < 88) begin
                len    = $urandom_range(1, 12);
                digits = $sformatf("%0d", len);
                q.insert(q.size(), $urandom_range(1) ? CH_PLUS : CH_MINUS);
                for (int i = 0; i < digits.len(); i++) q.insert(q.size(), digits[i]);
                repeat (len) q.insert(q.size(), bases[$urandom_range(9)]);
            end else if (kind < 97) begin
                // indel with no digits, zero length, or a length that does not
                // match what follows (up to past saturation)
                if ($urandom_range(3) == 0) digits = "";
                else if ($urandom_range(1)) digits = $sformatf("%0d", $urandom_range(30));
                else digits = $sformatf("%0d", $urandom_range(200000));
                q.insert(q.size(), $urandom_range(1) ? CH_PLUS : CH_MINUS);
                for (int i = 0; i < digits.len(); i++) q.insert(q.size(), digits[i]);
                repeat ($urandom_range(6)) q.insert(q.size(), bases[$urandom_range(9)]);
            end else begin
                q.insert(q.size(), 8'($urandom_range(255)));
            end
        end
        return q;
    endfunction

    // Stream random strings until about budget characters have gone in.
    task automatic run_reads(int budget);
        string      bases = "ATGCN";
        int         start, pick;
        logic [7:0] rb;
        start = chars_sent;
        while (chars_sent - start < budget) begin
            pick = $urandom_range(9);
            if (pick < 8) rb = bases[$urandom_range(4)];
            else if (pick == 8) rb = 8'($urandom_range(255));
            else rb = bases[$urandom_range(4)] + CASE_OFS;   // lower case counts nothing
            send_string(random_read(), rb, $urandom_range(19) == 0);
        end
    endtask

    // Drop valid, drain every pending result, then let the pipe run empty.
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (board.due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        board.thr  = v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [THR_W-1:0] thr_plan [6];
        string            letters = "ATGCNatgcn";
        char_q_t          q;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_pileup_char = '0;
        s_ref_base    = '0;
        s_end_mark    = 1'b0;
        m_ready       = 1'b0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed strings under the reset threshold.
        // every base letter in mixed case
        send_string(to_chars("aTgCn"), 8'h00, 1'b0);
        // ref matches on a valid reference, gap marks and end-of-read mark
        send_string(to_chars("<.>*,$"), CH_G, 1'b0);
        // indel without digits, then a ref match against an invalid reference
        send_string(to_chars("+,"), 8'hFF, 1'b0);
        // read start skips its quality byte, one-base indel skips G
        q    = to_chars("^?A+1GT");
        q[1] = 8'hFF;
        send_string(q, CH_A, 1'b0);
        // zero-length indel, then a bad byte; the trailing A is ignored
        q    = to_chars("-0?A");
        q[2] = 8'h00;
        send_string(q, CH_N, 1'b0);
        // indel length past saturation, string ends mid-indel
        send_string(to_chars("+70000"), CH_T, 1'b0);

        thr_plan    = '{17'd65536, 17'd0, 17'd0, 17'd32768, 17'd1, THR_RESET};
        thr_plan[2] = THR_W'($urandom_range(65536));

        for (int p = 0; p < 6; p++) begin
            settle();
            write_threshold(thr_plan[p]);
            tx_idle_pct = (p < 2) ? 15 : (p < 4) ? 74 : 0;
            rx_idle_pct = (p < 2) ? 74 : (p < 4) ? 15 : 0;
            run_reads(125);
            if (p == 0) begin
                // hold off the receiver and keep feeding one-base strings so
                // the result pipe fills and s_ready drops
                hold_cycles = HOLD_LEN;
                repeat (40) send_char(letters[$urandom_range(9)], CH_A, 1'b1);
            end
            if (p == 2) begin
                // pause the sender until every result has been taken
                s_valid <= 1'b0;
                @(negedge aclk);
                while (board.due.size() != 0) @(negedge aclk);
            end
            run_reads(125);
        end

        settle();
        if (board.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
